[design/mmed_pkg.sv]
package mmed_pkg;

  localparam int MaxWindow  = 64;
  localparam int SampleBits = 16;
  localparam int IdxW       = $clog2(MaxWindow);
  localparam int LenW       = 7;
  localparam int ResetLen   = 64;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [LenW-1:0]              len_t;
  typedef logic [IdxW-1:0]              idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESTART,
    ST_DEL,
    ST_INS,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic restart;
    logic accept;
    logic del;
    logic ins;
    logic load;
    len_t len;
  } cmd_t;

  function automatic len_t clamp_len(input len_t raw);
    len_t res;
    res = raw;
    if (raw == '0) begin
      res = len_t'(1);
    end else if (raw > len_t'(MaxWindow)) begin
      res = len_t'(MaxWindow);
    end
    return res;
  endfunction

endpackage

[design/mmed_ctrl.sv]
module mmed_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic              m_axis_tready,
  output logic              m_axis_tvalid,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  mmed_pkg::len_t    cfg_data_i,
  output mmed_pkg::cmd_t    cmd_o
);

  mmed_pkg::state_e state_q, state_d;
  mmed_pkg::len_t   len_q, len_d;
  logic             out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mmed_pkg::ST_IDLE;
      len_q     <= mmed_pkg::len_t'(mmed_pkg::ResetLen);
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    len_d         = len_q;
    out_vld_d     = out_vld_q && !m_axis_tready;
    s_axis_tready = 1'b0;
    cfg_ready_o   = 1'b0;
    cmd_o         = '0;
    cmd_o.len     = len_q;
    unique case (state_q)
      mmed_pkg::ST_IDLE: begin
        cfg_ready_o   = 1'b1;
        s_axis_tready = !cfg_valid_i;
        if (cfg_valid_i) begin
          len_d   = mmed_pkg::clamp_len(cfg_data_i);
          state_d = mmed_pkg::ST_RESTART;
        end else if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          state_d      = mmed_pkg::ST_DEL;
        end
      end
      mmed_pkg::ST_RESTART: begin
        cmd_o.restart = 1'b1;
        state_d       = mmed_pkg::ST_IDLE;
      end
      mmed_pkg::ST_DEL: begin
        cmd_o.del = 1'b1;
        state_d   = mmed_pkg::ST_INS;
      end
      mmed_pkg::ST_INS: begin
        cmd_o.ins = 1'b1;
        state_d   = mmed_pkg::ST_OUT;
      end
      mmed_pkg::ST_OUT: begin
        if (!out_vld_q || m_axis_tready) begin
          cmd_o.load = 1'b1;
          out_vld_d  = 1'b1;
          state_d    = mmed_pkg::ST_IDLE;
        end
      end
      default: state_d = mmed_pkg::ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = out_vld_q;

endmodule

[design/mmed_hist.sv]
module mmed_hist (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mmed_pkg::cmd_t    cmd_i,
  input  mmed_pkg::sample_t sample_i,
  output mmed_pkg::sample_t old_o
);

  mmed_pkg::sample_t             mem [mmed_pkg::MaxWindow];
  logic [mmed_pkg::MaxWindow-1:0] vld_q, vld_d;
  mmed_pkg::idx_t                slot_q, slot_d;
  mmed_pkg::sample_t             rd_q;
  logic                          rd_vld_q, rd_vld_d;
  mmed_pkg::len_t                len_m1;

  assign len_m1 = cmd_i.len - mmed_pkg::len_t'(1);

  // ring of past samples, read old word before overwrite
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem[slot_q] <= sample_i;
      rd_q        <= mem[slot_q];
    end
  end

  always_comb begin
    vld_d    = vld_q;
    slot_d   = slot_q;
    rd_vld_d = rd_vld_q;
    if (cmd_i.restart) begin
      vld_d  = '0;
      slot_d = len_m1[mmed_pkg::IdxW-1:0];
    end else if (cmd_i.accept) begin
      rd_vld_d       = vld_q[slot_q];
      vld_d[slot_q]  = 1'b1;
      slot_d         = (slot_q == '0) ? len_m1[mmed_pkg::IdxW-1:0]
                                      : slot_q - mmed_pkg::idx_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      slot_q   <= mmed_pkg::idx_t'(mmed_pkg::MaxWindow - 1);
      rd_vld_q <= 1'b0;
    end else begin
      vld_q    <= vld_d;
      slot_q   <= slot_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // slots not written since restart read as zero, like the restart zeros
  assign old_o = rd_vld_q ? rd_q : '0;

endmodule

[design/mmed_sorter.sv]
module mmed_sorter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mmed_pkg::cmd_t    cmd_i,
  input  mmed_pkg::sample_t sample_i,
  input  mmed_pkg::sample_t old_i,
  output mmed_pkg::sample_t median_o,
  output mmed_pkg::sample_t min_o,
  output mmed_pkg::sample_t max_o
);

  mmed_pkg::sample_t v_q [mmed_pkg::MaxWindow];
  mmed_pkg::sample_t v_d [mmed_pkg::MaxWindow];
  mmed_pkg::sample_t x_q;
  mmed_pkg::sample_t med_q, min_q, max_q;
  mmed_pkg::sample_t med_sel, max_sel;
  logic [mmed_pkg::MaxWindow-1:0] act, le;
  mmed_pkg::len_t                 half;

  assign half = cmd_i.len >> 1;

  // per cell flags
  always_comb begin
    for (int i = 0; i < mmed_pkg::MaxWindow; i++) begin
      act[i] = mmed_pkg::len_t'(i + 1) < cmd_i.len;
      le[i]  = act[i] && (v_q[i] <= x_q);
    end
  end

  always_comb begin
    for (int i = 0; i < mmed_pkg::MaxWindow; i++) begin
      v_d[i] = v_q[i];
    end
    if (cmd_i.restart) begin
      for (int i = 0; i < mmed_pkg::MaxWindow; i++) begin
        v_d[i] = '0;
      end
    end else if (cmd_i.del) begin
      // drop the first cell equal to the leaving word
      for (int i = 0; i < mmed_pkg::MaxWindow - 1; i++) begin
        if (act[i] && (v_q[i] >= old_i)) begin
          v_d[i] = v_q[i+1];
        end
      end
    end else if (cmd_i.ins) begin
      v_d[0] = le[0] ? v_q[0] : x_q;
      for (int i = 1; i < mmed_pkg::MaxWindow; i++) begin
        if (le[i]) begin
          v_d[i] = v_q[i];
        end else if (le[i-1]) begin
          v_d[i] = x_q;
        end else begin
          v_d[i] = v_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mmed_pkg::MaxWindow; i++) begin
        v_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < mmed_pkg::MaxWindow; i++) begin
        v_q[i] <= v_d[i];
      end
    end
  end

  // one-hot pick of median and max cells
  always_comb begin
    med_sel = '0;
    max_sel = '0;
    for (int i = 0; i < mmed_pkg::MaxWindow; i++) begin
      if (mmed_pkg::len_t'(i) == half) begin
        med_sel = med_sel | v_q[i];
      end
      if (mmed_pkg::len_t'(i + 1) == cmd_i.len) begin
        max_sel = max_sel | v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q <= sample_i;
    end
    if (cmd_i.load) begin
      med_q <= med_sel;
      min_q <= v_q[0];
      max_q <= max_sel;
    end
  end

  assign median_o = med_q;
  assign min_o    = min_q;
  assign max_o    = max_q;

endmodule

[design/moving_median_min_max_core.sv]
// Sliding-window median filter. Each signed 16-bit sample on the slave stream
// yields one word on the master stream with the window median (sorted index
// length/2, the upper median for even lengths), minimum and maximum. The
// window holds the last window_length samples (1..64; 0 reads as 1, larger
// values as 64); a write on the cfg channel restarts the window filled with
// zeros, and those zeros count as samples until overwritten. The filter works
// through each sample in order: it accepts the sample and reads the leaving
// sample from the history memory, removes that from the sorted cell row,
// inserts the new sample, and loads the output register, which waits while
// an earlier result is not yet taken. The next sample is accepted while a
// result still waits on the master side. A cfg write passes a restart state.
module moving_median_min_max_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // max_value, min_value, median_value (MSB to LSB)
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i      // window_length
);

  mmed_pkg::cmd_t    cmd;
  mmed_pkg::sample_t old_val;
  mmed_pkg::sample_t med, mn, mx;

  mmed_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tready(m_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .cmd_o        (cmd)
  );

  mmed_hist u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .sample_i(s_axis_tdata),
    .old_o   (old_val)
  );

  mmed_sorter u_sorter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .sample_i(s_axis_tdata),
    .old_i   (old_val),
    .median_o(med),
    .min_o   (mn),
    .max_o   (mx)
  );

  assign m_axis_tdata = {mx, mn, med};

endmodule

[design/mmed_checker.sv]
module mmed_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // a sample keeps the block busy for the following cycles
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !cfg_ready_o ##1 !s_axis_tready)
    else $error("sample taken while previous one in work");

  // restart blocks samples in the cycle after the cfg write
  a_busy_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !s_axis_tready)
    else $error("sample taken during restart");

  // a new result never shows up right after an idle cycle
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without preceding work");

endmodule

bind moving_median_min_max_core mmed_checker u_mmed_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o)
);
